// ===== hdl/bse_pkg.sv =====
`timescale 1ns / 1ps

package bse_pkg;

  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         count_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic odd;
    logic shift;
  } cmd_t;

  typedef struct packed {
    count_t count;
    logic   last;
  } status_t;

endpackage

// ===== hdl/bse_datapath.sv =====
`timescale 1ns / 1ps

module bse_datapath
  import bse_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cmd_t    cmd_i,
  input  data_t   value_i,
  input  logic    cfg_we_i,
  input  logic    cfg_descending_i,
  output status_t status_o,
  output data_t   head_o
);

  data_t  elem_q [DEPTH];
  data_t  elem_d [DEPTH];
  count_t count_q, count_d;
  logic   desc_q, desc_d;
  logic   full;
  logic [DEPTH-2:0] swap;

  assign full = (count_q == CNT_W'(DEPTH));

  // compare-swap cells, one per neighbor pair
  always_comb begin
    for (int i = 0; i < DEPTH - 1; i++) begin
      swap[i] = cmd_i.sort && (1'(i) == cmd_i.odd) && (CNT_W'(i + 1) < count_q) &&
                (desc_q ? (elem_q[i] < elem_q[i + 1]) : (elem_q[i] > elem_q[i + 1]));
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      elem_d[i] = elem_q[i];
    end
    if (cmd_i.load && !full) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (CNT_W'(i) == count_q) begin
          elem_d[i] = value_i;
        end
      end
    end
    if (cmd_i.sort) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (swap[i]) begin
          elem_d[i]     = elem_q[i + 1];
          elem_d[i + 1] = elem_q[i];
        end
      end
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        elem_d[i] = elem_q[i + 1];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.load && !full) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.shift) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  assign desc_d = cfg_we_i ? cfg_descending_i : desc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      desc_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      desc_q  <= desc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      elem_q[i] <= elem_d[i];
    end
  end

  assign status_o.count = count_q;
  assign status_o.last  = (count_q == CNT_W'(1));
  assign head_o         = elem_q[0];

endmodule

// ===== hdl/bse_ctrl.sv =====
`timescale 1ns / 1ps

module bse_ctrl
  import bse_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_in_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  count_t phase_q, phase_d;
  count_t phase_next;

  assign phase_next = phase_q + CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && last_in_i) begin
          state_d = ST_SORT;
          phase_d = '0;
        end
      end
      ST_SORT: begin
        cmd_o.sort = 1'b1;
        cmd_o.odd  = phase_q[0];
        phase_d    = phase_next;
        if (phase_next >= status_i.count) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
        if (out_ready_i && status_i.last) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== hdl/bubble_sort_engine.sv =====
`timescale 1ns / 1ps

// Collects a set of signed 32-bit values, one beat per cycle, until a beat
// with last_in_i; beats beyond the DEPTH-entry store are dropped, but a
// dropped last still closes the set. The held n values are then sorted by a
// row of compare-swap cells doing one odd-even transposition phase per cycle,
// with the order taken from the descending register, and are emitted one
// beat per cycle from the head of the row while out_ready_i is high, the
// final one with last_out_o. The input stays stalled during sort and
// emission. The register is written through its own channel, which is
// always ready.

module bubble_sort_engine
  import bse_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  data_t value_i,
  input  logic  last_in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output data_t sorted_value_o,
  output logic  last_out_o,
  input  logic  cfg_valid_i,
  output logic  cfg_ready_o,
  input  logic  cfg_descending_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_in_i   (last_in_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  bse_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .value_i          (value_i),
    .cfg_we_i         (cfg_valid_i),
    .cfg_descending_i (cfg_descending_i),
    .status_o         (status),
    .head_o           (sorted_value_o)
  );

  assign last_out_o = status.last;

endmodule

// ===== hdl/bse_checker.sv =====
`timescale 1ns / 1ps

module bse_checker
  import bse_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_o,
  input logic  last_in_i,
  input logic  out_valid_o,
  input logic  out_ready_i,
  input data_t sorted_value_o,
  input logic  last_out_o
);

  // no input ready while sorted results are being emitted
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while emitting");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sorted_value_o)
      && $stable(last_out_o))
    else $error("stalled output beat changed");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_in_i |=> !in_ready_o)
    else $error("input still ready after last beat");

  a_set_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_out_o |=> !out_valid_o && in_ready_o)
    else $error("emission did not end after last beat");

endmodule

bind bubble_sort_engine bse_checker u_bse_checker (.*);

// ===== test/tb_bubble_sort_engine.sv =====
`timescale 1ns / 1ps

module tb_bubble_sort_engine;
  import bse_pkg::*;

  localparam int SETTLE     = 3 * DEPTH + 10;
  localparam int PHASE_BEATS = 115;

  // expected sorted output of each closed set, oldest first
  class sorted_set_tracker;
    data_t held[$];
    data_t want_value[$];
    logic  want_last[$];
    logic  descending;
    int    errors;
    int    beats;
    int    sets;
    int    checked;

    function new();
      descending = 1'b0;
      errors = 0;
      beats = 0;
      sets = 0;
      checked = 0;
    endfunction

    function void set_order(logic d);
      descending = d;
    endfunction

    function int pending();
      return want_value.size();
    endfunction

    function void note_input(data_t v, logic l);
      data_t a[$];
      data_t t;
      beats++;
      if (held.size() < DEPTH) held.push_back(v);
      if (!l) return;
      a = held;
      for (int p = 1; p < a.size(); p++) begin
        for (int i = 0; i + 1 < a.size(); i++) begin
          if (descending ? (a[i] < a[i+1]) : (a[i] > a[i+1])) begin
            t = a[i];
            a[i] = a[i+1];
            a[i+1] = t;
          end
        end
      end
      foreach (a[k]) begin
        want_value.push_back(a[k]);
        want_last.push_back(k == a.size() - 1);
      end
      held.delete();
      sets++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("mismatch: %s", msg);
    endtask

    task check_result(data_t v, logic l);
      data_t ev;
      logic  el;
      if (want_value.size() == 0) begin
        report($sformatf("unexpected beat value %0d last %0b", v, l));
        return;
      end
      ev = want_value.pop_front();
      el = want_last.pop_front();
      checked++;
      if (v !== ev) report($sformatf("sorted_value %0d, want %0d", v, ev));
      if (l !== el) report($sformatf("last_out %0b, want %0b (value %0d)", l, el, ev));
    endtask
  endclass

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  data_t value;
  logic  last_in;
  logic  out_valid;
  logic  out_ready;
  data_t sorted_value;
  logic  last_out;
  logic  cfg_valid;
  logic  cfg_ready;
  logic  cfg_desc;

  int in_idle_pct;
  int out_idle_pct;

  sorted_set_tracker sb;

  bubble_sort_engine dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .value_i         (value),
    .last_in_i       (last_in),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .sorted_value_o  (sorted_value),
    .last_out_o      (last_out),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_descending_i(cfg_desc)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(sorted_value, last_out);
  end

  // called at a falling edge, returns at a falling edge
  task send_beat(data_t v, logic l);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last_in  <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_input(v, l);
    @(negedge clk);
  endtask

  task send_set(data_t vals[$]);
    foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task write_order(logic d);
    cfg_valid <= 1'b1;
    cfg_desc  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_order(d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function data_t rand_value();
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3, 4: return data_t'($urandom_range(15)) - 8;
      default: return data_t'($urandom);
    endcase
  endfunction

  task run_phase(int phase, logic d, int in_pct, int out_pct);
    data_t vals[$];
    int    n;
    int    sent;
    write_order(d);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    sent = 0;
    n = 31 + phase;
    while (sent < PHASE_BEATS) begin
      vals.delete();
      repeat (n) vals.push_back(rand_value());
      send_set(vals);
      sent += n;
      case ($urandom_range(9))
        0:       n = $urandom_range(40, 33);
        1, 2:    n = $urandom_range(32, 9);
        default: n = $urandom_range(8, 1);
      endcase
    end
    drain();
  endtask

  initial begin
    data_t vals[$];
    sb = new();
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    value        = '0;
    last_in      = 1'b0;
    out_ready    = 1'b0;
    cfg_valid    = 1'b0;
    cfg_desc     = 1'b0;
    in_idle_pct  = 20;
    out_idle_pct = 20;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // ascending with extremes and duplicates, then a single value
    write_order(1'b0);
    vals = {32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1, 32'sd1, 32'sh80000001,
            32'sh7ffffffe, 32'sh0};
    send_set(vals);
    vals = {32'sd5};
    send_set(vals);
    drain();

    // descending
    write_order(1'b1);
    vals = {32'sh7fffffff, 32'sh80000000, -32'sd1, -32'sd1, 32'sh0, 32'sd2};
    send_set(vals);
    vals = {32'sh80000000};
    send_set(vals);
    drain();

    run_phase(1, 1'b0, 18, 49);
    run_phase(2, 1'b1, 49, 18);
    run_phase(3, 1'b0, 0, 0);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("covered %0d sets from %0d input beats, %0d sorted beats checked,",
             sb.sets, sb.beats, sb.checked);
    $display("both sort orders, single values, duplicates and store overflow");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout, %0d results still outstanding", sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
